/* rtl/nbrm_pkg.sv */
// Shared types and constants for the non-blank block rectangle merger.
// Holds the beat payload structs, register indexes and controller/datapath links.
// No dependencies.
package nbrm_pkg;

  localparam int MAX_COLUMNS_DEF = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 3'd4;

  typedef struct packed {
    logic operation;
    logic block_nonblank;
    logic row_end;
  } in_t;

  typedef struct packed {
    logic [16:0] rect_x_pixels;
    logic [15:0] rect_y_line;
    logic [16:0] rect_width_pixels;
    logic [15:0] rect_height_lines;
    logic        last_of_run;
  } out_t;

  typedef logic [2:0] scan_op_t;
  localparam scan_op_t SCAN_HOLD   = 3'd0;
  localparam scan_op_t SCAN_ZERO   = 3'd1;
  localparam scan_op_t SCAN_INC    = 3'd2;
  localparam scan_op_t SCAN_DEC    = 3'd3;
  localparam scan_op_t SCAN_RUN    = 3'd4;
  localparam scan_op_t SCAN_RUN_M1 = 3'd5;

  typedef struct packed {
    logic     accept;
    scan_op_t scan_op;
    logic     rows_inc;
    logic     retire_done;
    logic     run_update;
    logic     rd_en;
    logic     rd_at_run;
    logic     extend;
    logic     open;
    logic     emit_stage1;
    logic     emit_stage2;
    logic     push;
    logic     finish;
    logic     page_clear;
  } cmd_t;

  typedef struct packed {
    logic flush_op;
    logic retire_due;
    logic add_needed;
    logic start_at_scan;
    logic split_at_run;
    logic extend_ok;
    logic scan_end;
    logic scan_past_end;
    logic retire_hit;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage

/* rtl/nbrm_ctrl.sv */
// Sequencing state machine for the rectangle merger.
// Drives nbrm_datapath through nbrm_pkg::cmd_t and reads nbrm_pkg::status_t.
module nbrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nbrm_pkg::status_t status,
  output nbrm_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RT    = 4'd2;
  localparam logic [3:0] S_RTCHK = 4'd3;
  localparam logic [3:0] S_RUN   = 4'd4;
  localparam logic [3:0] S_ARRD  = 4'd5;
  localparam logic [3:0] S_ARCHK = 4'd6;
  localparam logic [3:0] S_DN    = 4'd7;
  localparam logic [3:0] S_UP    = 4'd8;
  localparam logic [3:0] S_FL    = 4'd9;
  localparam logic [3:0] S_E1    = 4'd10;
  localparam logic [3:0] S_E2    = 4'd11;
  localparam logic [3:0] S_PUSH  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  localparam logic [1:0] R_RT      = 2'd0;
  localparam logic [1:0] R_FL      = 2'd1;
  localparam logic [1:0] R_UP      = 2'd2;
  localparam logic [1:0] R_UPSTART = 2'd3;

  logic [3:0] state, state_next;
  logic [1:0] ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= R_RT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    cmd.scan_op = nbrm_pkg::SCAN_HOLD;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.flush_op) begin
          cmd.scan_op = nbrm_pkg::SCAN_ZERO;
          state_next  = S_FL;
        end else if (status.retire_due) begin
          cmd.scan_op = nbrm_pkg::SCAN_ZERO;
          state_next  = S_RT;
        end else begin
          cmd.rows_inc = 1'b1;
          state_next   = S_RUN;
        end
      end
      S_RT: begin
        if (status.scan_end) begin
          cmd.retire_done = 1'b1;
          state_next      = S_RUN;
        end else if (status.start_at_scan) begin
          cmd.rd_en  = 1'b1;
          state_next = S_RTCHK;
        end else begin
          cmd.scan_op = nbrm_pkg::SCAN_INC;
        end
      end
      S_RTCHK: begin
        if (status.retire_hit) begin
          ret_next   = R_RT;
          state_next = S_E1;
        end else begin
          cmd.scan_op = nbrm_pkg::SCAN_INC;
          state_next  = S_RT;
        end
      end
      S_RUN: begin
        cmd.run_update = 1'b1;
        state_next = status.add_needed ? S_ARRD : S_FIN;
      end
      S_ARRD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_at_run = 1'b1;
        state_next    = S_ARCHK;
      end
      S_ARCHK: begin
        if (status.extend_ok) begin
          cmd.extend = 1'b1;
          state_next = S_FIN;
        end else if (status.split_at_run) begin
          cmd.scan_op = nbrm_pkg::SCAN_RUN_M1;
          state_next  = S_DN;
        end else begin
          cmd.scan_op = nbrm_pkg::SCAN_RUN;
          state_next  = S_UP;
        end
      end
      S_DN: begin
        if (status.start_at_scan) begin
          cmd.rd_en  = 1'b1;
          ret_next   = R_UPSTART;
          state_next = S_E1;
        end else begin
          cmd.scan_op = nbrm_pkg::SCAN_DEC;
        end
      end
      S_UP: begin
        if (status.scan_past_end) begin
          cmd.open   = 1'b1;
          state_next = S_FIN;
        end else if (status.start_at_scan) begin
          cmd.rd_en  = 1'b1;
          ret_next   = R_UP;
          state_next = S_E1;
        end else begin
          cmd.scan_op = nbrm_pkg::SCAN_INC;
        end
      end
      S_FL: begin
        if (status.scan_end) begin
          cmd.page_clear = 1'b1;
          state_next     = S_FIN;
        end else if (status.start_at_scan) begin
          cmd.rd_en  = 1'b1;
          ret_next   = R_FL;
          state_next = S_E1;
        end else begin
          cmd.scan_op = nbrm_pkg::SCAN_INC;
        end
      end
      S_E1: begin
        cmd.emit_stage1 = 1'b1;
        state_next      = S_E2;
      end
      S_E2: begin
        cmd.emit_stage2 = 1'b1;
        state_next      = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          unique case (ret)
            R_RT: begin
              cmd.scan_op = nbrm_pkg::SCAN_INC;
              state_next  = S_RT;
            end
            R_FL: begin
              cmd.scan_op = nbrm_pkg::SCAN_INC;
              state_next  = S_FL;
            end
            R_UP: begin
              cmd.scan_op = nbrm_pkg::SCAN_INC;
              state_next  = S_UP;
            end
            default: begin
              cmd.scan_op = nbrm_pkg::SCAN_RUN;
              state_next  = S_UP;
            end
          endcase
        end
      end
      S_FIN: begin
        if (status.out_free || !status.pend_valid) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/nbrm_datapath.sv */
// Page state, rectangle store and output staging for the rectangle merger.
// Uses nbrm_pkg for payload, command and status types.
module nbrm_datapath #(
  parameter int MAX_COLUMNS = nbrm_pkg::MAX_COLUMNS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [nbrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nbrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  nbrm_pkg::in_t                     in_data,
  output nbrm_pkg::out_t                    out_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  nbrm_pkg::cmd_t                    cmd,
  output nbrm_pkg::status_t                 status
);

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int SCAN_W = COL_W + 1;
  localparam int XW     = (COL_W + 9 > 14) ? COL_W + 9 : 14;

  typedef struct packed {
    logic [COL_W-1:0] right;
    logic [15:0]      top;
    logic [15:0]      bottom;
  } rect_t;

  // configuration
  logic [7:0]  bw, bh, win;
  logic [6:0]  cols;
  logic [13:0] lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      bw   <= 8'd1;
      bh   <= 8'd1;
      win  <= 8'd1;
      cols <= 7'd64;
      lb   <= 14'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        nbrm_pkg::CFG_BLOCK_WIDTH:  bw   <= cfg_data[7:0];
        nbrm_pkg::CFG_BLOCK_HEIGHT: bh   <= cfg_data[7:0];
        nbrm_pkg::CFG_WINDOW_ROWS:  win  <= cfg_data[7:0];
        nbrm_pkg::CFG_COLUMNS:      cols <= cfg_data[6:0];
        nbrm_pkg::CFG_LINE_BYTES:   lb   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic [7:0] bw_eff, bh_eff, win_eff, cols_eff;
  assign bw_eff  = (bw == 8'd0) ? 8'd1 : bw;
  assign bh_eff  = (bh == 8'd0) ? 8'd1 : bh;
  assign win_eff = (win == 8'd0) ? 8'd1 : win;
  always_comb begin
    cols_eff = {1'b0, cols};
    if (cols == 7'd0) cols_eff = 8'd1;
    if ({1'b0, cols} > 8'(MAX_COLUMNS)) cols_eff = 8'(MAX_COLUMNS);
  end

  // page state
  nbrm_pkg::in_t      in_q;
  logic [COL_W-1:0]   cur_col, run_s, ar_s, ar_e;
  logic               run_active;
  logic [15:0]        cur_row, oldest;
  logic [7:0]         rows_held;
  logic [SCAN_W-1:0]  scan;
  logic [MAX_COLUMNS-1:0] own, start;
  logic               is_end;

  assign is_end = in_q.row_end || (8'(cur_col) + 8'd1 >= cols_eff);

  always_ff @(posedge clk) begin
    if (cmd.accept) in_q <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.page_clear) begin
      run_active <= 1'b0;
      run_s      <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      oldest     <= '0;
      rows_held  <= '0;
    end else begin
      if (cmd.retire_done) oldest <= oldest + 16'd1;
      if (cmd.rows_inc && cur_col == '0 && rows_held != 8'hFF)
        rows_held <= rows_held + 8'd1;
      if (cmd.run_update) begin
        ar_s <= run_active ? run_s : cur_col;
        ar_e <= in_q.block_nonblank ? cur_col : cur_col - COL_W'(1);
        if (in_q.block_nonblank) begin
          if (!run_active) begin
            run_active <= 1'b1;
            run_s      <= cur_col;
          end
        end else begin
          run_active <= 1'b0;
        end
        if (is_end) run_active <= 1'b0;
      end
      if (cmd.finish && !in_q.operation) begin
        if (is_end) begin
          cur_col <= '0;
          cur_row <= cur_row + 16'd1;
        end else begin
          cur_col <= cur_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.scan_op)
      nbrm_pkg::SCAN_ZERO:   scan <= '0;
      nbrm_pkg::SCAN_INC:    scan <= scan + SCAN_W'(1);
      nbrm_pkg::SCAN_DEC:    scan <= scan - SCAN_W'(1);
      nbrm_pkg::SCAN_RUN:    scan <= {1'b0, ar_s};
      nbrm_pkg::SCAN_RUN_M1: scan <= {1'b0, ar_s - COL_W'(1)};
      default:               scan <= scan;
    endcase
  end

  // rectangle store, indexed by left column
  rect_t            mem [MAX_COLUMNS];
  rect_t            rd_q;
  logic [COL_W-1:0] rd_addr, rd_addr_d;

  assign rd_addr_d = cmd.rd_at_run ? ar_s : scan[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.open) begin
      mem[ar_s] <= '{right: ar_e, top: cur_row, bottom: cur_row};
    end else if (cmd.extend) begin
      mem[ar_s] <= '{right: rd_q.right, top: rd_q.top, bottom: cur_row};
    end
    if (cmd.rd_en) begin
      rd_q    <= mem[rd_addr_d];
      rd_addr <= rd_addr_d;
    end
  end

  // column ownership: intervals stay disjoint, start marks each left edge
  always_ff @(posedge clk) begin
    if (rst || cmd.page_clear) begin
      own   <= '0;
      start <= '0;
    end else begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        if (cmd.emit_stage1 && COL_W'(c) >= rd_addr && COL_W'(c) <= rd_q.right)
          own[c] <= 1'b0;
        if (cmd.emit_stage1 && COL_W'(c) == rd_addr)
          start[c] <= 1'b0;
        if (cmd.open && COL_W'(c) >= ar_s && COL_W'(c) <= ar_e)
          own[c] <= 1'b1;
        if (cmd.open && COL_W'(c) == ar_s)
          start[c] <= 1'b1;
      end
    end
  end

  // emit pipeline: products, then clip and saturate
  logic [XW-1:0] x0_q, xe_q;
  logic [23:0]   y_q;
  logic [24:0]   h_q;
  logic [15:0]   row_diff;
  logic [16:0]   span;
  nbrm_pkg::out_t res_q;

  // row difference wraps at 16 bits before the +1
  assign row_diff = rd_q.bottom - rd_q.top;
  assign span     = {1'b0, row_diff} + 17'd1;

  always_ff @(posedge clk) begin
    if (cmd.emit_stage1) begin
      x0_q <= XW'(rd_addr) * XW'(bw_eff);
      xe_q <= (XW'(rd_q.right) + XW'(1)) * XW'(bw_eff);
      y_q  <= rd_q.top * bh_eff;
      h_q  <= span * bh_eff;
    end
  end

  logic [XW-1:0] xe_clip, xe_fix;
  always_comb begin
    xe_clip = (xe_q > XW'(lb)) ? XW'(lb) : xe_q;
    xe_fix  = (xe_clip <= x0_q) ? x0_q + XW'(1) : xe_clip;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stage2) begin
      res_q.rect_x_pixels     <= 17'({x0_q, 3'b000});
      res_q.rect_width_pixels <= 17'({xe_fix - x0_q, 3'b000});
      res_q.rect_y_line       <= (|y_q[23:16]) ? 16'hFFFF : y_q[15:0];
      res_q.rect_height_lines <= (|h_q[24:16]) ? 16'hFFFF : h_q[15:0];
      res_q.last_of_run       <= 1'b0;
    end
  end

  // one result held back so the final beat of an item can carry last_of_run
  nbrm_pkg::out_t pend, pend_last;
  logic           pend_valid;

  always_comb begin
    pend_last             = pend;
    pend_last.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (pend_valid) out_data <= pend;
        out_valid  <= pend_valid || (out_valid && !out_ready);
        pend       <= res_q;
        pend_valid <= 1'b1;
      end else if (cmd.finish && pend_valid) begin
        out_data   <= pend_last;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  logic [15:0] age;
  assign age = oldest - rd_q.top;

  always_comb begin
    status.flush_op      = in_q.operation;
    status.retire_due    = (cur_col == '0) && (rows_held >= win_eff);
    status.add_needed    = (!in_q.block_nonblank && run_active) ||
                           (in_q.block_nonblank && is_end);
    status.start_at_scan = start[scan[COL_W-1:0]];
    status.split_at_run  = own[ar_s] && !start[ar_s];
    status.extend_ok     = start[ar_s] && (rd_q.bottom == cur_row - 16'd1) &&
                           (rd_q.right == ar_e);
    status.scan_end      = (scan == SCAN_W'(MAX_COLUMNS));
    status.scan_past_end = (scan > {1'b0, ar_e});
    status.retire_hit    = !age[15];
    status.out_free      = !out_valid || out_ready;
    status.pend_valid    = pend_valid;
  end

endmodule

/* rtl/nonblank_block_rectangle_merger_core.sv */
// Non-blank block rectangle merger, top level. Depends on nbrm_pkg, nbrm_ctrl, nbrm_datapath.
// Takes one input beat at a time: in_ready is high only in the idle state, so the next
// beat waits until the previous one has extended or opened its rectangle, walked the
// columns, emitted rectangles and waited for the output register to free. Retire sweep and
// page flush walk every column. Reset (rst, sync) clears controller, page, ownership and
// output valid state and loads the default configuration; the rectangle store is not reset.
module nonblank_block_rectangle_merger_core #(
  parameter int MAX_COLUMNS = nbrm_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [nbrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nbrm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nbrm_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nbrm_pkg::out_t                  out_data
);

  // Controller walks the column sweeps; datapath owns the page state and the
  // output register, so a finished beat waits there while the next item starts.
  nbrm_pkg::cmd_t    cmd;
  nbrm_pkg::status_t status;

  nbrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nbrm_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* dv/nonblank_block_rectangle_merger_core_tb.sv */
// Testbench for the non-blank block rectangle merger core: drives block flags and page
// flushes, predicts every emitted rectangle and checks each output beat in order.
// Depends on nbrm_pkg and nonblank_block_rectangle_merger_core.
`timescale 1ns / 1ps

module nonblank_block_rectangle_merger_core_tb;

  localparam int NCOL = 64;
  localparam int CYCLE_LIMIT = 5000000;

  // Predictor of rectangle merging; holds its own page state and registers.
  class rect_scoreboard;
    int unsigned bw, bh, win, cols, lbytes;
    bit [5:0]  left_c [NCOL];
    bit [5:0]  right_c [NCOL];
    bit [15:0] top_r [NCOL];
    bit [15:0] bot_r [NCOL];
    bit [6:0]  owner [NCOL];
    bit [5:0]  free_q [NCOL];
    int unsigned free_n;
    bit        in_run;
    int unsigned run_col, cur_col;
    bit [15:0] cur_row, oldest_row;
    int unsigned held;
    nbrm_pkg::out_t pending_rects[$];
    int unsigned errors, checked;

    function new();
      bw = 1; bh = 1; win = 1; cols = 64; lbytes = 64;
      errors = 0; checked = 0;
      clear_page();
    endfunction

    function void clear_page();
      for (int i = 0; i < NCOL; i++) begin
        left_c[i] = '0; right_c[i] = '0; top_r[i] = '0; bot_r[i] = '0; owner[i] = '0;
        free_q[i] = 6'(NCOL - 1 - i);
      end
      free_n = NCOL; in_run = 0; run_col = 0; cur_col = 0;
      cur_row = '0; oldest_row = '0; held = 0;
    endfunction

    function void write_reg(logic [nbrm_pkg::CFG_IDX_W-1:0] idx,
                            logic [nbrm_pkg::CFG_DATA_W-1:0] v);
      case (idx)
        nbrm_pkg::CFG_BLOCK_WIDTH:  bw = {24'd0, v[7:0]};
        nbrm_pkg::CFG_BLOCK_HEIGHT: bh = {24'd0, v[7:0]};
        nbrm_pkg::CFG_WINDOW_ROWS:  win = {24'd0, v[7:0]};
        nbrm_pkg::CFG_COLUMNS:      cols = {25'd0, v[6:0]};
        nbrm_pkg::CFG_LINE_BYTES:   lbytes = {18'd0, v[13:0]};
        default: ;
      endcase
    endfunction

    function void emit_rect(int unsigned slot);
      int unsigned w, h, x0, xe, y, hh;
      nbrm_pkg::out_t r;
      w = (bw == 0) ? 1 : bw;
      h = (bh == 0) ? 1 : bh;
      x0 = left_c[slot] * w;
      xe = (right_c[slot] + 1) * w;
      if (xe > lbytes) xe = lbytes;
      if (xe <= x0) xe = x0 + 1;
      y = top_r[slot] * h;
      if (y > 65535) y = 65535;
      hh = ((bot_r[slot] - top_r[slot]) & 16'hFFFF) + 1;
      hh = hh * h;
      if (hh > 65535) hh = 65535;
      r.rect_x_pixels = 17'(x0 * 8);
      r.rect_y_line = 16'(y);
      r.rect_width_pixels = 17'((xe - x0) * 8);
      r.rect_height_lines = 16'(hh);
      r.last_of_run = 1'b0;
      pending_rects.push_back(r);
      for (int c = 0; c < NCOL; c++)
        if (owner[c] == {1'b1, 6'(slot)}) owner[c] = '0;
      if (free_n < NCOL) begin
        free_q[free_n] = 6'(slot);
        free_n++;
      end
    endfunction

    function void close_run(int unsigned s, int unsigned e);
      int unsigned slot;
      if (owner[s][6]) begin
        slot = 32'(owner[s][5:0]);
        if (bot_r[slot] == 16'(cur_row - 1) && left_c[slot] == s && right_c[slot] == e) begin
          bot_r[slot] = cur_row;
          return;
        end
      end
      for (int c = s; c <= e; c++)
        if (owner[c][6]) emit_rect(32'(owner[c][5:0]));
      if (free_n == 0) return;
      free_n--;
      slot = 32'(free_q[free_n]);
      left_c[slot] = 6'(s); right_c[slot] = 6'(e);
      top_r[slot] = cur_row; bot_r[slot] = cur_row;
      for (int c = s; c <= e; c++) owner[c] = {1'b1, 6'(slot)};
    endfunction

    // Note one accepted input beat and queue the rectangles it causes.
    function void note_input(nbrm_pkg::in_t it);
      int unsigned n0, ncols, col, w, slot;
      bit last_col;
      n0 = pending_rects.size();
      if (it.operation) begin
        for (int c = 0; c < NCOL; c++)
          if (owner[c][6]) emit_rect(32'(owner[c][5:0]));
        clear_page();
      end else begin
        ncols = (cols == 0) ? 1 : cols;
        if (ncols > NCOL) ncols = NCOL;
        col = cur_col;
        last_col = it.row_end || (col + 1 >= ncols);
        if (col == 0) begin
          w = (win == 0) ? 1 : win;
          if (held >= w) begin
            for (int c = 0; c < NCOL; c++) begin
              if (!owner[c][6]) continue;
              slot = 32'(owner[c][5:0]);
              if (16'(oldest_row - top_r[slot]) < 16'h8000) emit_rect(slot);
            end
            held--;
            oldest_row++;
          end
          if (held < 255) held++;
        end
        if (it.block_nonblank) begin
          if (!in_run) begin
            in_run = 1; run_col = col;
          end
        end else if (in_run) begin
          close_run(run_col, col - 1);
          in_run = 0;
        end
        if (last_col) begin
          if (in_run) close_run(run_col, col);
          in_run = 0; cur_col = 0; cur_row++;
        end else begin
          cur_col = (col + 1) & 63;
        end
      end
      if (pending_rects.size() > n0)
        pending_rects[pending_rects.size() - 1].last_of_run = 1'b1;
    endfunction

    // Compare one output beat with the oldest expected rectangle.
    function void check_rect(nbrm_pkg::out_t got);
      nbrm_pkg::out_t want;
      checked++;
      if (pending_rects.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected rectangle %p", got);
        return;
      end
      want = pending_rects.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("rectangle mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write;
  logic [nbrm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nbrm_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  nbrm_pkg::in_t  in_data;
  nbrm_pkg::out_t out_data;

  rect_scoreboard sb;
  int unsigned cycle_count;
  int unsigned beats_sent, flushes_sent;
  bit long_holdoff, sending_done;

  nonblank_block_rectangle_merger_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Write one register, then idle with cfg_write low; the block must be idle.
  task automatic write_reg(logic [nbrm_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= nbrm_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    sb.write_reg(idx, nbrm_pkg::CFG_DATA_W'(v));
    cfg_write <= 0;
    @(posedge clk);
  endtask

  // Offer one beat and hold it until accepted, then idle for a random gap.
  task automatic send_beat(bit op, bit nonblank, bit rend);
    nbrm_pkg::in_t it;
    int unsigned gap;
    it.operation = op;
    it.block_nonblank = nonblank;
    it.row_end = rend;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    beats_sent++;
    if (op) flushes_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait until every expected rectangle has arrived, then let sweeps finish.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_rects.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // One block row of random flags, mostly full width, some cut short by row_end.
  task automatic send_row(int unsigned ncols, int unsigned density);
    int unsigned len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ncols) : ncols;
    for (int c = 0; c < len; c++)
      send_beat(0, $urandom_range(0, 99) < density,
                (c == len - 1 && len < ncols) ? 1'b1 : 1'($urandom_range(0, 30) == 0));
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned ncols);
    int unsigned start, r;
    start = beats_sent;
    while (beats_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) send_row(ncols, $urandom_range(20, 90));
      else if (r < 90) send_beat(1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else send_beat(0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    send_beat(1, 0, 0);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int unsigned gap;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_holdoff) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_holdoff = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  // Check each accepted output beat.
  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_rect(out_data);

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sb = new();
    cycle_count = 0; beats_sent = 0; flushes_sent = 0;
    long_holdoff = 0; sending_done = 0;
    rst = 1; cfg_write = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_data = '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: narrow page with extremes of the registers.
    write_reg(nbrm_pkg::CFG_BLOCK_WIDTH, 255);
    write_reg(nbrm_pkg::CFG_BLOCK_HEIGHT, 255);
    write_reg(nbrm_pkg::CFG_WINDOW_ROWS, 1);
    write_reg(nbrm_pkg::CFG_COLUMNS, 2);
    write_reg(nbrm_pkg::CFG_LINE_BYTES, 300);
    send_beat(0, 1, 0); send_beat(0, 1, 0);   // run to row end at last column
    send_beat(0, 1, 0); send_beat(0, 1, 0);   // retired at next row start, so a new run opens
    send_beat(0, 0, 0); send_beat(0, 1, 0);   // different extents
    send_beat(0, 1, 0); send_beat(0, 0, 0);   // run closed by blank block
    send_beat(0, 1, 1); send_beat(0, 0, 1);   // row_end early
    send_beat(1, 1, 1);                        // flush drops partial run state
    drain();
    write_reg(nbrm_pkg::CFG_COLUMNS, 64);
    write_reg(nbrm_pkg::CFG_LINE_BYTES, 1);    // right clip below left edge
    write_reg(nbrm_pkg::CFG_WINDOW_ROWS, 255);
    write_reg(nbrm_pkg::CFG_BLOCK_WIDTH, 1);
    for (int c = 0; c < 8; c++) send_beat(0, c[0], 0);
    send_beat(0, 1, 1);
    send_beat(0, 1, 0); send_beat(1, 0, 0);    // flush with unfinished row
    drain();

    // Random phases over several settings; small column counts keep rows short.
    write_reg(nbrm_pkg::CFG_LINE_BYTES, 16383);
    write_reg(nbrm_pkg::CFG_BLOCK_HEIGHT, 1);
    write_reg(nbrm_pkg::CFG_WINDOW_ROWS, 3);
    write_reg(nbrm_pkg::CFG_COLUMNS, 8);
    random_phase(50, 8);
    drain();

    write_reg(nbrm_pkg::CFG_BLOCK_WIDTH, $urandom_range(1, 255));
    write_reg(nbrm_pkg::CFG_BLOCK_HEIGHT, $urandom_range(1, 255));
    write_reg(nbrm_pkg::CFG_WINDOW_ROWS, 1);
    write_reg(nbrm_pkg::CFG_COLUMNS, 12);
    write_reg(nbrm_pkg::CFG_LINE_BYTES, $urandom_range(1, 16383));
    long_holdoff = 1;                          // fill the block while output stalls
    random_phase(60, 12);
    drain();                                   // sender pauses until all results arrive

    write_reg(nbrm_pkg::CFG_BLOCK_WIDTH, 0);
    write_reg(nbrm_pkg::CFG_BLOCK_HEIGHT, 0);
    write_reg(nbrm_pkg::CFG_WINDOW_ROWS, 0);
    write_reg(nbrm_pkg::CFG_COLUMNS, 0);
    write_reg(nbrm_pkg::CFG_LINE_BYTES, 0);
    random_phase(20, 1);
    drain();

    write_reg(nbrm_pkg::CFG_BLOCK_WIDTH, 8);
    write_reg(nbrm_pkg::CFG_BLOCK_HEIGHT, 16);
    write_reg(nbrm_pkg::CFG_WINDOW_ROWS, 2);
    write_reg(nbrm_pkg::CFG_COLUMNS, 127);     // clamps to the full width
    write_reg(nbrm_pkg::CFG_LINE_BYTES, 400);
    random_phase(70, 64);
    drain();

    $display("sent %0d beats (%0d flushes), checked %0d rectangles",
             beats_sent, flushes_sent, sb.checked);
    if (sb.errors == 0 && sb.pending_rects.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d rectangles never seen", sb.errors, sb.pending_rects.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* nonblank_block_rectangle_merger_core.f */
rtl/nbrm_pkg.sv
rtl/nbrm_ctrl.sv
rtl/nbrm_datapath.sv
rtl/nonblank_block_rectangle_merger_core.sv
dv/nonblank_block_rectangle_merger_core_tb.sv
